/* hw/rtl/pcb_pkg.sv */
// Shared types, constants and helpers for the particle cell binning block.
// No dependencies; every other file in hw/rtl uses it by scoped names.
package pcb_pkg;

    localparam int CELLS_PER_AXIS = 16;
    localparam int FILL_BITS      = 16;

    localparam int NCELLS    = CELLS_PER_AXIS * CELLS_PER_AXIS * CELLS_PER_AXIS;
    localparam int CELL_BITS = (NCELLS > 1) ? $clog2(NCELLS) : 1;

    localparam int POS_BITS      = 32;
    localparam int EDGE_BITS     = 31;
    localparam int CNT_BITS      = 5;
    localparam int GRID_BITS     = 15;
    localparam int IDX_OUT_BITS  = 12;
    localparam int SLOT_BITS     = 16;
    localparam int NUM_BITS      = 32;
    localparam int STATUS_BITS   = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int DIV_STEPS     = POS_BITS;
    localparam int STEP_BITS     = $clog2(DIV_STEPS);
    localparam int Q_DEPTH       = 2;
    localparam int Q_PTR_BITS    = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS    = $clog2(Q_DEPTH + 1);

    localparam logic [FILL_BITS-1:0] FILL_MAX = {FILL_BITS{1'b1}};
    localparam logic [NUM_BITS-1:0]  NUM_MAX  = {NUM_BITS{1'b1}};

    localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_OUTSIDE = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_EDGE_X   = 3'd3,
        REG_EDGE_Y   = 3'd4,
        REG_EDGE_Z   = 3'd5,
        REG_GRID     = 3'd6,
        REG_PERIODIC = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [2:0][POS_BITS-1:0]  origin;
        logic [2:0][EDGE_BITS-1:0] edge_len;
        logic [GRID_BITS-1:0]      grid;
        logic                      periodic;
    } t_cfg;

    // One classified particle handed from front to back.
    typedef struct packed {
        logic                 outside;
        logic [CELL_BITS-1:0] idx;
        logic [EDGE_BITS-1:0] lx;
        logic [EDGE_BITS-1:0] ly;
        logic [EDGE_BITS-1:0] lz;
    } t_item;

    // Cell count field: 0 reads as 1, above the grid size reads as the grid size.
    function automatic logic [CNT_BITS-1:0] count_clamp(input logic [CNT_BITS-1:0] f);
        logic [CNT_BITS-1:0] res;
        res = f;
        if (f == '0) begin
            res = CNT_BITS'(1);
        end else if (int'(f) > CELLS_PER_AXIS) begin
            res = CNT_BITS'(CELLS_PER_AXIS);
        end
        return res;
    endfunction

endpackage

/* hw/rtl/pcb_axis_div.sv */
// Bit-serial floor divider for one axis: |pos - origin| / edge, one quotient bit a cycle.
// Also keeps the quotient modulo the cell count. Depends on pcb_pkg.
module pcb_axis_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [pcb_pkg::POS_BITS-1:0]        i_pos,
    input  logic [pcb_pkg::POS_BITS-1:0]        i_origin,
    input  logic [pcb_pkg::EDGE_BITS-1:0]       i_edge,
    input  logic [pcb_pkg::CNT_BITS-1:0]        i_n,
    output logic                                o_last,
    output logic                                o_neg,
    output logic [pcb_pkg::POS_BITS-1:0]        o_quo,
    output logic [pcb_pkg::EDGE_BITS-1:0]       o_rem,
    output logic [pcb_pkg::CNT_BITS-1:0]        o_mod
);

    logic                                r_busy;
    logic [pcb_pkg::STEP_BITS-1:0]       r_cnt;
    logic                                r_neg;
    logic [pcb_pkg::POS_BITS-1:0]        r_dvd;
    logic [pcb_pkg::POS_BITS-1:0]        r_quo;
    logic [pcb_pkg::EDGE_BITS-1:0]       r_rem;
    logic [pcb_pkg::CNT_BITS-1:0]        r_mod;

    logic [pcb_pkg::POS_BITS:0]          rel;
    logic [pcb_pkg::POS_BITS-1:0]        mag;
    logic [pcb_pkg::POS_BITS-1:0]        cand;
    logic                                ge;
    logic [pcb_pkg::CNT_BITS:0]          mm;

    assign rel  = {i_pos[pcb_pkg::POS_BITS-1], i_pos}
                - {i_origin[pcb_pkg::POS_BITS-1], i_origin};
    assign mag  = rel[pcb_pkg::POS_BITS] ? pcb_pkg::POS_BITS'(-rel)
                                         : rel[pcb_pkg::POS_BITS-1:0];
    assign cand = {r_rem, r_dvd[pcb_pkg::POS_BITS-1]};
    assign ge   = cand >= {1'b0, i_edge};
    assign mm   = {r_mod, ge};

    assign o_last = r_busy && (r_cnt == pcb_pkg::STEP_BITS'(pcb_pkg::DIV_STEPS - 1));
    assign o_neg  = r_neg;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_mod  = r_mod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (o_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= rel[pcb_pkg::POS_BITS];
            r_dvd <= mag;
            r_quo <= '0;
            r_rem <= '0;
            r_mod <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[pcb_pkg::POS_BITS-2:0], 1'b0};
            r_quo <= {r_quo[pcb_pkg::POS_BITS-2:0], ge};
            r_rem <= ge ? pcb_pkg::EDGE_BITS'(cand - {1'b0, i_edge})
                        : pcb_pkg::EDGE_BITS'(cand);
            // running quotient mod n, stays below n
            r_mod <= (mm >= {1'b0, i_n}) ? pcb_pkg::CNT_BITS'(mm - {1'b0, i_n})
                                         : pcb_pkg::CNT_BITS'(mm);
        end
    end

endmodule

/* hw/rtl/pcb_front.sv */
// Front end: takes a particle, runs the three axis dividers, classifies it
// and pushes the finished item into the queue. Depends on pcb_pkg, pcb_axis_div.
module pcb_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pcb_pkg::t_cfg                 i_cfg,
    input  logic                          i_hold,
    input  logic                          i_valid,
    input  logic [pcb_pkg::POS_BITS-1:0]  i_pos_x,
    input  logic [pcb_pkg::POS_BITS-1:0]  i_pos_y,
    input  logic [pcb_pkg::POS_BITS-1:0]  i_pos_z,
    output logic                          o_ready,
    input  logic                          i_q_full,
    output logic                          o_push,
    output pcb_pkg::t_item                o_item
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_FIN  = 4'b0100,
        S_PUSH = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic                                   start;
    logic [2:0][pcb_pkg::POS_BITS-1:0]      pos;
    logic [2:0][pcb_pkg::EDGE_BITS-1:0]     e;
    logic [2:0][pcb_pkg::CNT_BITS-1:0]      n;
    logic [2:0]                             last;
    logic [2:0]                             neg;
    logic [2:0][pcb_pkg::POS_BITS-1:0]      quo;
    logic [2:0][pcb_pkg::EDGE_BITS-1:0]     rem;
    logic [2:0][pcb_pkg::CNT_BITS-1:0]      md;

    logic [2:0][pcb_pkg::CNT_BITS-1:0]      coord;
    logic [2:0][pcb_pkg::EDGE_BITS-1:0]     loc;
    logic [2:0]                             in_grid;
    logic [pcb_pkg::CNT_BITS:0]             t [3];

    logic [2:0][pcb_pkg::CNT_BITS-1:0]      r_c;
    logic [2:0][pcb_pkg::EDGE_BITS-1:0]     r_l;
    logic                                   r_outside;
    logic [2*pcb_pkg::CNT_BITS-1:0]         r_nxy;
    logic [pcb_pkg::CELL_BITS-1:0]          idx;

    assign pos = {i_pos_z, i_pos_y, i_pos_x};
    assign o_ready = (r_state == S_IDLE) && !i_hold;
    assign start   = o_ready && i_valid;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            e[a] = (i_cfg.edge_len[a] == '0) ? pcb_pkg::EDGE_BITS'(1) : i_cfg.edge_len[a];
            n[a] = pcb_pkg::count_clamp(i_cfg.grid[a*pcb_pkg::CNT_BITS +: pcb_pkg::CNT_BITS]);
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        pcb_axis_div u_div (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_start  (start),
            .i_pos    (pos[a]),
            .i_origin (i_cfg.origin[a]),
            .i_edge   (e[a]),
            .i_n      (n[a]),
            .o_last   (last[a]),
            .o_neg    (neg[a]),
            .o_quo    (quo[a]),
            .o_rem    (rem[a]),
            .o_mod    (md[a])
        );
    end

    // Floor correction: a negative offset with a nonzero remainder steps one cell down.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            loc[a]     = (neg[a] && rem[a] != '0) ? e[a] - rem[a] : rem[a];
            in_grid[a] = !neg[a] && (quo[a] < pcb_pkg::POS_BITS'(n[a]));
            t[a]       = {1'b0, md[a]} + {{pcb_pkg::CNT_BITS{1'b0}}, (rem[a] != '0)};
            if (t[a] == {1'b0, n[a]}) begin
                t[a] = '0;
            end
            if (!i_cfg.periodic) begin
                coord[a] = quo[a][pcb_pkg::CNT_BITS-1:0];
            end else if (!neg[a] || t[a] == '0) begin
                coord[a] = neg[a] ? '0 : md[a];
            end else begin
                coord[a] = n[a] - pcb_pkg::CNT_BITS'(t[a]);
            end
        end
    end

    assign idx = pcb_pkg::CELL_BITS'(r_c[2]) * pcb_pkg::CELL_BITS'(r_nxy)
               + pcb_pkg::CELL_BITS'(r_c[1]) * pcb_pkg::CELL_BITS'(n[0])
               + pcb_pkg::CELL_BITS'(r_c[0]);

    assign o_push         = (r_state == S_PUSH) && !i_q_full;
    assign o_item.outside = r_outside;
    assign o_item.idx     = idx;
    assign o_item.lx      = r_l[0];
    assign o_item.ly      = r_l[1];
    assign o_item.lz      = r_l[2];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (start) n_state = S_DIV;
            S_DIV:  if (&last) n_state = S_FIN;
            S_FIN:  n_state = S_PUSH;
            S_PUSH: if (!i_q_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN) begin
            r_c       <= coord;
            r_l       <= loc;
            r_outside <= !i_cfg.periodic && !(&in_grid);
            r_nxy     <= (2*pcb_pkg::CNT_BITS)'(n[0]) * (2*pcb_pkg::CNT_BITS)'(n[1]);
        end
    end

endmodule

/* hw/rtl/pcb_queue.sv */
// Short FIFO of classified items between front and back.
// Depends on pcb_pkg.
module pcb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pcb_pkg::t_item  i_item,
    input  logic            i_pop,
    output pcb_pkg::t_item  o_item,
    output logic            o_full,
    output logic            o_empty
);

    pcb_pkg::t_item                  r_mem [pcb_pkg::Q_DEPTH];
    logic [pcb_pkg::Q_PTR_BITS-1:0]  r_wp;
    logic [pcb_pkg::Q_PTR_BITS-1:0]  r_rp;
    logic [pcb_pkg::Q_CNT_BITS-1:0]  r_cnt;

    assign o_full  = r_cnt == pcb_pkg::Q_CNT_BITS'(pcb_pkg::Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + pcb_pkg::Q_CNT_BITS'(i_push) - pcb_pkg::Q_CNT_BITS'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

/* hw/rtl/pcb_back.sv */
// Back end: clears the per-cell fill memory after reset, then updates fill and
// total counters per in-grid item and holds the result word. Depends on pcb_pkg.
module pcb_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_empty,
    input  pcb_pkg::t_item                       i_item,
    output logic                                 o_pop,
    output logic                                 o_clearing,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [pcb_pkg::STATUS_BITS-1:0]      o_status,
    output logic [pcb_pkg::IDX_OUT_BITS-1:0]     o_cell_index,
    output logic [pcb_pkg::SLOT_BITS-1:0]        o_slot,
    output logic [pcb_pkg::EDGE_BITS-1:0]        o_local_x,
    output logic [pcb_pkg::EDGE_BITS-1:0]        o_local_y,
    output logic [pcb_pkg::EDGE_BITS-1:0]        o_local_z,
    output logic [pcb_pkg::NUM_BITS-1:0]         o_particle_number
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_WAIT  = 3'b100
    } t_state;

    t_state r_state;

    logic [pcb_pkg::FILL_BITS-1:0]  r_fill_mem [pcb_pkg::NCELLS];
    logic [pcb_pkg::FILL_BITS-1:0]  r_rd;
    logic [pcb_pkg::CELL_BITS-1:0]  r_clr_addr;
    logic [pcb_pkg::NUM_BITS-1:0]   r_total;
    pcb_pkg::t_item                 r_item;

    logic                           r_ov;
    logic [pcb_pkg::STATUS_BITS-1:0] r_status;
    logic [pcb_pkg::CELL_BITS-1:0]  r_idx;
    logic [pcb_pkg::SLOT_BITS-1:0]  r_slot;
    logic [pcb_pkg::EDGE_BITS-1:0]  r_lx, r_ly, r_lz;
    logic [pcb_pkg::NUM_BITS-1:0]   r_pnum;

    logic                           out_free;
    logic                           cell_full;
    logic                           mem_we;
    logic [pcb_pkg::CELL_BITS-1:0]  mem_wa;
    logic [pcb_pkg::FILL_BITS-1:0]  mem_wd;

    assign out_free   = !r_ov || !i_stall;
    assign o_pop      = (r_state == S_IDLE) && !i_q_empty && out_free;
    assign o_clearing = r_state == S_CLEAR;
    assign cell_full  = r_rd == pcb_pkg::FILL_MAX;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_item.idx;
        mem_wd = r_rd + 1'b1;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr_addr;
            mem_wd = '0;
        end else if (r_state == S_WAIT) begin
            mem_we = !cell_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_fill_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_fill_mem[i_item.idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_total    <= '0;
            r_ov       <= 1'b0;
        end else begin
            // result held while stalled; outside words load at pop, others after the read
            r_ov <= (r_ov && i_stall) || (o_pop && i_item.outside)
                 || (r_state == S_WAIT);
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == pcb_pkg::CELL_BITS'(pcb_pkg::NCELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_pop && !i_item.outside) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_state <= S_IDLE;
                    if (!cell_full && r_total != pcb_pkg::NUM_MAX) begin
                        r_total <= r_total + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item   <= i_item;
            r_status <= pcb_pkg::ST_OUTSIDE;
            r_idx    <= '0;
            r_slot   <= '0;
            r_lx     <= '0;
            r_ly     <= '0;
            r_lz     <= '0;
            r_pnum   <= '0;
        end else if (r_state == S_WAIT) begin
            r_status <= cell_full ? pcb_pkg::ST_FULL : pcb_pkg::ST_OK;
            r_idx    <= r_item.idx;
            r_lx     <= r_item.lx;
            r_ly     <= r_item.ly;
            r_lz     <= r_item.lz;
            r_slot   <= cell_full ? '0 : pcb_pkg::SLOT_BITS'(r_rd);
            r_pnum   <= cell_full ? '0 : r_total;
        end
    end

    assign o_valid           = r_ov;
    assign o_status          = r_status;
    assign o_cell_index      = pcb_pkg::IDX_OUT_BITS'(r_idx);
    assign o_slot            = r_slot;
    assign o_local_x         = r_lx;
    assign o_local_y         = r_ly;
    assign o_local_z         = r_lz;
    assign o_particle_number = r_pnum;

endmodule

/* hw/rtl/particle_cell_binning.sv */
// Top level of the particle cell binning block: configuration registers,
// front end, item queue and back end. Depends on pcb_pkg and all pcb_* modules.
//
// Bins one Q16.16 particle position per input word into a 3D cell list.
// Each axis is floor-divided by its cell edge in a bit-serial divider, one
// quotient bit per cycle; the front end takes a new word only after the last
// has passed accept, the divider steps, classify and the queue push, which
// waits while the queue is full. The back end reads and bumps the cell's fill
// counter and holds the result word in an output register, so a stalled output
// does not hold up the next division until the queue fills. After reset the
// fill memory is swept to zero, one cell a cycle, over all NCELLS (4096) cells;
// input stall stays high meanwhile, while configuration writes are taken as ever.
// Write configuration only while the block is idle.
module particle_cell_binning (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [pcb_pkg::CFG_IDX_BITS-1:0]        i_cfg_idx,
    input  logic [pcb_pkg::CFG_DATA_BITS-1:0]       i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [pcb_pkg::POS_BITS-1:0]            i_pos_x,
    input  logic [pcb_pkg::POS_BITS-1:0]            i_pos_y,
    input  logic [pcb_pkg::POS_BITS-1:0]            i_pos_z,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic [pcb_pkg::STATUS_BITS-1:0]         o_status,
    output logic [pcb_pkg::IDX_OUT_BITS-1:0]        o_cell_index,
    output logic [pcb_pkg::SLOT_BITS-1:0]           o_slot,
    output logic [pcb_pkg::EDGE_BITS-1:0]           o_local_x,
    output logic [pcb_pkg::EDGE_BITS-1:0]           o_local_y,
    output logic [pcb_pkg::EDGE_BITS-1:0]           o_local_z,
    output logic [pcb_pkg::NUM_BITS-1:0]            o_particle_number
);

    pcb_pkg::t_cfg   r_cfg;
    pcb_pkg::t_item  push_item;
    pcb_pkg::t_item  head_item;
    logic            front_ready;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    logic            clearing;

    // Configuration registers, truncated to each register's width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin   <= '0;
            r_cfg.edge_len <= {3{pcb_pkg::EDGE_BITS'(65536)}};
            r_cfg.grid     <= pcb_pkg::GRID_BITS'(16912);
            r_cfg.periodic <= 1'b0;
        end else if (i_cfg_we) begin
            case (pcb_pkg::t_reg_idx'(i_cfg_idx))
                pcb_pkg::REG_ORIGIN_X: r_cfg.origin[0]   <= i_cfg_data;
                pcb_pkg::REG_ORIGIN_Y: r_cfg.origin[1]   <= i_cfg_data;
                pcb_pkg::REG_ORIGIN_Z: r_cfg.origin[2]   <= i_cfg_data;
                pcb_pkg::REG_EDGE_X:   r_cfg.edge_len[0] <= pcb_pkg::EDGE_BITS'(i_cfg_data);
                pcb_pkg::REG_EDGE_Y:   r_cfg.edge_len[1] <= pcb_pkg::EDGE_BITS'(i_cfg_data);
                pcb_pkg::REG_EDGE_Z:   r_cfg.edge_len[2] <= pcb_pkg::EDGE_BITS'(i_cfg_data);
                pcb_pkg::REG_GRID:     r_cfg.grid        <= pcb_pkg::GRID_BITS'(i_cfg_data);
                pcb_pkg::REG_PERIODIC: r_cfg.periodic    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Front: division and classification; held off while the fill memory clears.
    pcb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_hold   (clearing),
        .i_valid  (i_in_valid),
        .i_pos_x  (i_pos_x),
        .i_pos_y  (i_pos_y),
        .i_pos_z  (i_pos_z),
        .o_ready  (front_ready),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (push_item)
    );

    assign o_in_stall = !front_ready;

    pcb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: fill counters, running particle number, result register.
    pcb_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (q_empty),
        .i_item            (head_item),
        .o_pop             (pop),
        .o_clearing        (clearing),
        .o_valid           (o_out_valid),
        .i_stall           (i_out_stall),
        .o_status          (o_status),
        .o_cell_index      (o_cell_index),
        .o_slot            (o_slot),
        .o_local_x         (o_local_x),
        .o_local_y         (o_local_y),
        .o_local_z         (o_local_z),
        .o_particle_number (o_particle_number)
    );

    // No particle enters while the fill memory is still being cleared.
    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> o_in_stall)
        else $error("input accepted during fill memory clear");

    // The front never pushes into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("push into full queue");

    // A rejected-outside word carries no cell, slot or number.
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == pcb_pkg::ST_OUTSIDE) |->
        (o_cell_index == '0 && o_slot == '0 && o_particle_number == '0))
        else $error("outside result with nonzero fields");

endmodule
